// File: rtl/round_robin_chunk_splitter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin chunk splitter
// Each macro expands to a labeled concurrent assertion, or to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_CHUNK_SPLITTER_ASSERT_SVH
`define ROUND_ROBIN_CHUNK_SPLITTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define RRCS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define RRCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RRCS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define RRCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// File: rtl/rrcs_pkg.sv
// ----------------------------------------------------------------------------
// rrcs_pkg
// Shared types and constants of the round-robin chunk splitter.
// ----------------------------------------------------------------------------
package rrcs_pkg;

   localparam int unsigned LEN_W      = 32;
   localparam int unsigned CNT_W      = 64;
   localparam int unsigned CHUNK_W    = 32;
   localparam int unsigned WIDX_W     = 4;
   localparam int unsigned COUNT_W    = 5;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_WRITER_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LIMIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORD_LIMIT = 2'd2;

   // per-writer running state
   typedef struct packed {
      logic [CNT_W-1:0]   bases;
      logic [CNT_W-1:0]   records;
      logic [CHUNK_W-1:0] chunk;
   } writer_state_type;

   // state update request toward the writer store
   typedef struct packed {
      logic             en;
      writer_state_type data;
   } state_write_type;

endpackage

// File: rtl/rrcs_state_mem.sv
// ----------------------------------------------------------------------------
// rrcs_state_mem
// Per-writer state store with registered read, write-through bypass and
// valid bits that make untouched entries read as their reset values.
// ----------------------------------------------------------------------------
module rrcs_state_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  rrcs_pkg::state_write_type   wr,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [ADDR_W-1:0]           rd_addr,
   output rrcs_pkg::writer_state_type  rd_state
);

   rrcs_pkg::writer_state_type mem [DEPTH];
   rrcs_pkg::writer_state_type rd_data_ff;
   logic [DEPTH-1:0]           valid_ff;
   logic                       rd_valid_ff;
   logic [ADDR_W-1:0]          rd_addr_ff;
   logic                       bypass;

   assign bypass = wr.en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= bypass ? wr.data : mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= bypass || valid_ff[rd_addr];
      end
   end

   // untouched entry: zero counts, chunk number equal to the writer number
   always_comb begin
      if (rd_valid_ff) begin
         rd_state = rd_data_ff;
      end else begin
         rd_state.bases   = '0;
         rd_state.records = '0;
         rd_state.chunk   = rrcs_pkg::CHUNK_W'(rd_addr_ff);
      end
   end

endmodule

// File: rtl/round_robin_chunk_splitter.sv
// ----------------------------------------------------------------------------
// round_robin_chunk_splitter
// Deals records round-robin over writers and closes chunks on size limits.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req_record_length) carries one record
//   length. Response channel (rsp_*) returns one result per request: writer,
//   chunk, closed flag, running base and record counts, and the next chunk.
//   Configuration (csr_we/csr_index/csr_wdata) writes writer_count, base_limit
//   and record_limit; write only while idle. Writing writer_count restarts
//   the partition: every writer returns to chunk = own number, counts zero.
//   A request taken passes the input register, then the response register.
//   Throughput: one request per cycle unless rsp_ready stalls, set by the single
//   state read, add/compare and write-back path around the per-writer state
//   store, which reads the next writer ahead and forwards same-writer updates.
//   Reset: synchronous, active high; one writer, no limits, first free chunk
//   is 1. No clearing pass: valid bits mark written store entries.
//   Stall: when rsp_ready is low the response register holds, one more request
//   waits in the input register, then req_ready drops.
// ----------------------------------------------------------------------------
`include "round_robin_chunk_splitter_assert.svh"

module round_robin_chunk_splitter #(
   parameter int MAX_WRITERS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rrcs_pkg::LEN_W-1:0]        req_record_length,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rrcs_pkg::WIDX_W-1:0]       rsp_writer_index,
   output logic [rrcs_pkg::CHUNK_W-1:0]      rsp_chunk_number,
   output logic                              rsp_chunk_closed,
   output logic [rrcs_pkg::CNT_W-1:0]        rsp_chunk_bases,
   output logic [rrcs_pkg::CNT_W-1:0]        rsp_chunk_records,
   output logic [rrcs_pkg::CHUNK_W-1:0]      rsp_next_chunk_number,
   // configuration write port
   input  logic                              csr_we,
   input  logic [rrcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rrcs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int PTR_W = (MAX_WRITERS > 1) ? $clog2(MAX_WRITERS) : 1;
   localparam int CAP   = (MAX_WRITERS < 31) ? MAX_WRITERS : 31;

   localparam logic [rrcs_pkg::COUNT_W-1:0] COUNT_RESET = 5'd1;

   // clamp the writer count to 1..CAP
   function automatic logic [rrcs_pkg::COUNT_W-1:0] effective_count(
      input logic [rrcs_pkg::COUNT_W-1:0] cnt
   );
      logic [rrcs_pkg::COUNT_W-1:0] res;
      priority if (cnt == '0) begin
         res = 5'd1;
      end else if (cnt > rrcs_pkg::COUNT_W'(CAP)) begin
         res = rrcs_pkg::COUNT_W'(CAP);
      end else begin
         res = cnt;
      end
      return res;
   endfunction

   // configuration registers
   logic [rrcs_pkg::COUNT_W-1:0]   count_ff;
   logic [rrcs_pkg::CNT_W-1:0]     base_limit_ff;
   logic [rrcs_pkg::CNT_W-1:0]     record_limit_ff;

   // input stage
   logic                           in_valid_ff;
   logic [rrcs_pkg::LEN_W-1:0]     in_len_ff;

   // sequencing state
   logic [PTR_W-1:0]               tp_ff, tp_in, tp_next;
   logic [rrcs_pkg::CHUNK_W-1:0]   free_chunk_ff;

   // response register
   logic                           rsp_valid_ff;
   logic [rrcs_pkg::WIDX_W-1:0]    rsp_writer_index_ff;
   logic [rrcs_pkg::CHUNK_W-1:0]   rsp_chunk_number_ff;
   logic                           rsp_chunk_closed_ff;
   logic [rrcs_pkg::CNT_W-1:0]     rsp_chunk_bases_ff;
   logic [rrcs_pkg::CNT_W-1:0]     rsp_chunk_records_ff;
   logic [rrcs_pkg::CHUNK_W-1:0]   rsp_next_chunk_number_ff;

   // datapath
   logic [rrcs_pkg::COUNT_W-1:0]   n_eff;
   logic                           advance;
   logic                           restart;
   logic                           wrap;
   logic [rrcs_pkg::CNT_W:0]       bases_sum;
   logic [rrcs_pkg::CNT_W-1:0]     bases;
   logic [rrcs_pkg::CNT_W-1:0]     recs;
   logic                           closed;
   logic [rrcs_pkg::CHUNK_W-1:0]   next_chunk;
   rrcs_pkg::writer_state_type     cur;
   rrcs_pkg::state_write_type      wr;

   assign n_eff   = effective_count(count_ff);
   assign restart = csr_we && (csr_index == rrcs_pkg::CSR_WRITER_COUNT);

   // fire when the input holds a request and the response slot frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // configuration writes; out-of-range index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= COUNT_RESET;
         base_limit_ff   <= '0;
         record_limit_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rrcs_pkg::CSR_WRITER_COUNT: count_ff <= csr_wdata[rrcs_pkg::COUNT_W-1:0];
            rrcs_pkg::CSR_BASE_LIMIT:   base_limit_ff <= csr_wdata;
            rrcs_pkg::CSR_RECORD_LIMIT: record_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_len_ff <= req_record_length;
      end
   end

   // per-writer state; read address runs one step ahead of the turn pointer
   rrcs_state_mem #(
      .DEPTH  (MAX_WRITERS),
      .ADDR_W (PTR_W)
   ) u_state (
      .clock    (clock),
      .reset    (reset),
      .clear    (restart),
      .wr       (wr),
      .wr_addr  (tp_ff),
      .rd_addr  (tp_in),
      .rd_state (cur)
   );

   // add the record, saturating, and test both limits
   always_comb begin
      bases_sum  = {1'b0, cur.bases} + {{(rrcs_pkg::CNT_W + 1 - rrcs_pkg::LEN_W){1'b0}}, in_len_ff};
      bases      = bases_sum[rrcs_pkg::CNT_W] ? '1 : bases_sum[rrcs_pkg::CNT_W-1:0];
      recs       = (&cur.records) ? cur.records : cur.records + 64'd1;
      closed     = ((base_limit_ff != '0) && (bases >= base_limit_ff)) ||
                   ((record_limit_ff != '0) && (recs >= record_limit_ff));
      next_chunk = closed ? free_chunk_ff : cur.chunk;

      // write back: a closed chunk hands the writer a fresh one with zero counts
      wr.en = advance;
      if (closed) begin
         wr.data.bases   = '0;
         wr.data.records = '0;
      end else begin
         wr.data.bases   = bases;
         wr.data.records = recs;
      end
      wr.data.chunk = next_chunk;
   end

   // advance the turn, wrapping after the last writer in use
   assign wrap    = (int'(tp_ff) + 1) >= int'(n_eff);
   assign tp_next = wrap ? '0 : tp_ff + 1'b1;

   always_comb begin
      priority if (restart) begin
         tp_in = '0;
      end else if (advance) begin
         tp_in = tp_next;
      end else begin
         tp_in = tp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tp_ff         <= '0;
         free_chunk_ff <= rrcs_pkg::CHUNK_W'(effective_count(COUNT_RESET));
      end else begin
         tp_ff <= tp_in;
         priority if (restart) begin
            free_chunk_ff <= rrcs_pkg::CHUNK_W'(
               effective_count(csr_wdata[rrcs_pkg::COUNT_W-1:0]));
         end else if (advance && closed) begin
            free_chunk_ff <= free_chunk_ff + 32'd1;
         end
      end
   end

   // response register: load on advance, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_writer_index_ff      <= rrcs_pkg::WIDX_W'(tp_ff);
         rsp_chunk_number_ff      <= cur.chunk;
         rsp_chunk_closed_ff      <= closed;
         rsp_chunk_bases_ff       <= bases;
         rsp_chunk_records_ff     <= recs;
         rsp_next_chunk_number_ff <= next_chunk;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_writer_index      = rsp_writer_index_ff;
   assign rsp_chunk_number      = rsp_chunk_number_ff;
   assign rsp_chunk_closed      = rsp_chunk_closed_ff;
   assign rsp_chunk_bases       = rsp_chunk_bases_ff;
   assign rsp_chunk_records     = rsp_chunk_records_ff;
   assign rsp_next_chunk_number = rsp_next_chunk_number_ff;

   // turn pointer never leaves the writers in use
   `RRCS_ASSERT_IMPLIES(a_ptr_range, clock, reset, 1'b1, int'(tp_ff) < int'(n_eff), "turn pointer out of range")
   // an open chunk continues with the same chunk number
   `RRCS_ASSERT_IMPLIES(a_open_keeps_chunk, clock, reset, rsp_valid_ff && !rsp_chunk_closed_ff, rsp_next_chunk_number_ff == rsp_chunk_number_ff, "open chunk changed number")
   // each close consumes exactly one free chunk number
   `RRCS_ASSERT_NEXT(a_free_chunk_step, clock, reset, advance && closed && !restart, free_chunk_ff == $past(free_chunk_ff) + 32'd1, "free chunk did not step")
   // a fired request always lands in the response register
   `RRCS_ASSERT_NEXT(a_rsp_loaded, clock, reset, advance, rsp_valid_ff, "response lost")

endmodule

// File: bench/round_robin_chunk_splitter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_chunk_splitter_tb
// Self-checking bench for the round-robin chunk splitter. It streams record
// lengths through valid/ready and predicts every writer, chunk, count and
// close decision. A short directed run covers the field and limit extremes,
// then randomized batches run under changing register settings and idling.
// ----------------------------------------------------------------------------
module round_robin_chunk_splitter_tb;

   localparam int MAX_WRITERS     = 16;
   localparam int RANDOM_RECORDS  = 1150;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;

   // index 3 is not mapped; writes to it must leave every register alone
   localparam logic [rrcs_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   // one expected response: where a record lands and what its chunk holds
   typedef struct {
      logic [rrcs_pkg::WIDX_W-1:0]  writer_index;
      logic [rrcs_pkg::CHUNK_W-1:0] chunk_number;
      logic                         chunk_closed;
      logic [rrcs_pkg::CNT_W-1:0]   chunk_bases;
      logic [rrcs_pkg::CNT_W-1:0]   chunk_records;
      logic [rrcs_pkg::CHUNK_W-1:0] next_chunk_number;
   } placement_type;

   logic                            clock             = 1'b0;
   logic                            reset             = 1'b1;
   logic                            req_valid         = 1'b0;
   logic                            req_ready;
   logic [rrcs_pkg::LEN_W-1:0]      req_record_length = '0;
   logic                            rsp_valid;
   logic                            rsp_ready         = 1'b0;
   logic [rrcs_pkg::WIDX_W-1:0]     rsp_writer_index;
   logic [rrcs_pkg::CHUNK_W-1:0]    rsp_chunk_number;
   logic                            rsp_chunk_closed;
   logic [rrcs_pkg::CNT_W-1:0]      rsp_chunk_bases;
   logic [rrcs_pkg::CNT_W-1:0]      rsp_chunk_records;
   logic [rrcs_pkg::CHUNK_W-1:0]    rsp_next_chunk_number;
   logic                            csr_we            = 1'b0;
   logic [rrcs_pkg::CSR_IDX_W-1:0]  csr_index         = '0;
   logic [rrcs_pkg::CSR_DATA_W-1:0] csr_wdata         = '0;

   // record lengths waiting for the driver, and responses still owed
   logic [rrcs_pkg::LEN_W-1:0] queued_lengths[$];
   placement_type              expected_placements[$];

   // idling knobs and the one long receiver hold-off, set from the sequence
   int send_idle_pct    = 0;
   int recv_idle_pct    = 0;
   bit hold_off_request = 1'b0;
   int hold_cycles_left = 0;
   int error_count      = 0;
   int stalled_cycles   = 0;

   // splitter shadow: registers and per-writer running state
   logic [rrcs_pkg::COUNT_W-1:0] cfg_writer_count = 5'd1;
   logic [rrcs_pkg::CNT_W-1:0]   cfg_base_limit   = '0;
   logic [rrcs_pkg::CNT_W-1:0]   cfg_record_limit = '0;
   logic [rrcs_pkg::CNT_W-1:0]   wr_bases[MAX_WRITERS];
   logic [rrcs_pkg::CNT_W-1:0]   wr_records[MAX_WRITERS];
   logic [rrcs_pkg::CHUNK_W-1:0] wr_chunk[MAX_WRITERS];
   int unsigned                  turn;
   logic [rrcs_pkg::CHUNK_W-1:0] free_chunk;

   round_robin_chunk_splitter #(
      .MAX_WRITERS(MAX_WRITERS)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_record_length    (req_record_length),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_writer_index     (rsp_writer_index),
      .rsp_chunk_number     (rsp_chunk_number),
      .rsp_chunk_closed     (rsp_chunk_closed),
      .rsp_chunk_bases      (rsp_chunk_bases),
      .rsp_chunk_records    (rsp_chunk_records),
      .rsp_next_chunk_number(rsp_next_chunk_number),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Shadow model
   // ------------------------------------------------------------------------

   // zero counts as one writer, anything past the array saturates
   function automatic int unsigned writers_in_use();
      int unsigned n;
      n = cfg_writer_count;
      if (n == 0) n = 1;
      if (n > MAX_WRITERS) n = MAX_WRITERS;
      return n;
   endfunction

   // new partition: every writer back on its own chunk with empty counts
   function automatic void restart_partition();
      for (int i = 0; i < MAX_WRITERS; i++) begin
         wr_bases[i]   = '0;
         wr_records[i] = '0;
         wr_chunk[i]   = rrcs_pkg::CHUNK_W'(i);
      end
      turn       = 0;
      free_chunk = writers_in_use();
   endfunction

   function automatic void update_settings(input logic [rrcs_pkg::CSR_IDX_W-1:0] idx,
                                           input logic [rrcs_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         rrcs_pkg::CSR_WRITER_COUNT: begin
            cfg_writer_count = data[rrcs_pkg::COUNT_W-1:0];
            restart_partition();
         end
         rrcs_pkg::CSR_BASE_LIMIT:   cfg_base_limit   = data;
         rrcs_pkg::CSR_RECORD_LIMIT: cfg_record_limit = data;
         default: ;
      endcase
   endfunction

   // hand one record to the writer whose turn it is and queue the response
   function automatic void place_record(input logic [rrcs_pkg::LEN_W-1:0] len);
      int unsigned              n;
      int unsigned              w;
      logic [rrcs_pkg::CNT_W:0] wide_sum;
      placement_type            p;
      n = writers_in_use();
      w = (turn >= n) ? 0 : turn;
      wide_sum        = {1'b0, wr_bases[w]} + (rrcs_pkg::CNT_W + 1)'(len);
      p.chunk_bases   = wide_sum[rrcs_pkg::CNT_W] ? '1 : wide_sum[rrcs_pkg::CNT_W-1:0];
      p.chunk_records = (wr_records[w] == '1) ? '1 : wr_records[w] + 1'b1;
      p.writer_index  = w[rrcs_pkg::WIDX_W-1:0];
      p.chunk_number  = wr_chunk[w];
      p.chunk_closed  = (cfg_base_limit != 0 && p.chunk_bases >= cfg_base_limit) ||
                        (cfg_record_limit != 0 && p.chunk_records >= cfg_record_limit);
      if (p.chunk_closed) begin
         // close: take the next free chunk and restart the counts
         p.next_chunk_number = free_chunk;
         free_chunk          = free_chunk + 1'b1;
         wr_chunk[w]         = p.next_chunk_number;
         wr_bases[w]         = '0;
         wr_records[w]       = '0;
      end else begin
         p.next_chunk_number = p.chunk_number;
         wr_bases[w]         = p.chunk_bases;
         wr_records[w]       = p.chunk_records;
      end
      turn = (w + 1 >= n) ? 0 : w + 1;
      expected_placements.push_back(p);
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: accept, predict, then offer the next queued length
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict at the accepting edge so model order matches the block
         if (req_valid && req_ready) place_record(req_record_length);
         // hold valid and payload until the request is taken
         if (!req_valid || req_ready) begin
            if (queued_lengths.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid         <= 1'b1;
               req_record_length <= queued_lengths.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: check each response against the oldest expectation
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [rrcs_pkg::CNT_W-1:0] want,
                              input logic [rrcs_pkg::CNT_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      placement_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_placements.size() == 0) begin
               $display("%0t: unexpected response, expected none, got writer %0d chunk %0d",
                        $time, rsp_writer_index, rsp_chunk_number);
               error_count++;
            end else begin
               want = expected_placements.pop_front();
               check_field("writer_index", rrcs_pkg::CNT_W'(want.writer_index),
                           rrcs_pkg::CNT_W'(rsp_writer_index));
               check_field("chunk_number", rrcs_pkg::CNT_W'(want.chunk_number),
                           rrcs_pkg::CNT_W'(rsp_chunk_number));
               check_field("chunk_closed", rrcs_pkg::CNT_W'(want.chunk_closed),
                           rrcs_pkg::CNT_W'(rsp_chunk_closed));
               check_field("chunk_bases", want.chunk_bases, rsp_chunk_bases);
               check_field("chunk_records", want.chunk_records, rsp_chunk_records);
               check_field("next_chunk_number", rrcs_pkg::CNT_W'(want.next_chunk_number),
                           rrcs_pkg::CNT_W'(rsp_next_chunk_number));
            end
         end
         // long hold-off: drop ready and let the block back up into its input
         if (hold_cycles_left > 0) begin
            hold_cycles_left--;
            rsp_ready <= 1'b0;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_cycles_left = HOLD_OFF_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run if no handshake completes for too long
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stalled_cycles = 0;
      else
         stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL round_robin_chunk_splitter");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   // wait until every queued request went in and every response came back
   task automatic settle();
      @(negedge clock);
      while (queued_lengths.size() != 0 || req_valid || expected_placements.size() != 0)
         @(negedge clock);
   endtask

   // write one register while idle and mirror it into the shadow model
   task automatic write_csr(input logic [rrcs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rrcs_pkg::CSR_DATA_W-1:0] data);
      settle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      update_settings(idx, data);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int                         random_sent;
      int                         batch;
      bit                         hold_off_done;
      logic [rrcs_pkg::LEN_W-1:0] len;
      logic [rrcs_pkg::CNT_W-1:0] limit;

      random_sent   = 0;
      hold_off_done = 1'b0;
      restart_partition();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // one writer, no limits: lengths at both extremes pile into chunk 0
      queued_lengths.push_back('0);
      queued_lengths.push_back('1);
      queued_lengths.push_back(32'd1);

      // record limit set with counts kept: the first record closes at once
      write_csr(rrcs_pkg::CSR_RECORD_LIMIT, 64'd2);
      queued_lengths.push_back(32'd5);
      queued_lengths.push_back(32'd7);
      queued_lengths.push_back(32'd9);

      // writer count with low bits zero acts as one writer, upper bits dropped
      write_csr(rrcs_pkg::CSR_WRITER_COUNT, 64'hFFFF_FFFF_FFFF_FFE0);
      queued_lengths.push_back(32'd3);
      queued_lengths.push_back(32'd4);

      // writer count past the array saturates; walk all writers and wrap
      write_csr(rrcs_pkg::CSR_WRITER_COUNT, 64'd31);
      write_csr(rrcs_pkg::CSR_RECORD_LIMIT, 64'd0);
      write_csr(rrcs_pkg::CSR_BASE_LIMIT, 64'd1);
      for (int i = 0; i < MAX_WRITERS + 1; i++)
         queued_lengths.push_back(i[0] ? 32'd1 : 32'd0);

      // unmapped index is ignored, then both limits at their top value
      write_csr(CSR_UNMAPPED, '1);
      write_csr(rrcs_pkg::CSR_BASE_LIMIT, '1);
      write_csr(rrcs_pkg::CSR_RECORD_LIMIT, '1);

      // random batches, each under a freshly drawn setting
      while (random_sent < RANDOM_RECORDS) begin
         if (random_sent >= RANDOM_RECORDS * 2 / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (random_sent >= RANDOM_RECORDS / 3) begin
            send_idle_pct = 67;
            recv_idle_pct = 7;
         end else begin
            send_idle_pct = 7;
            recv_idle_pct = 67;
         end

         // restart the partition now and then, mostly with few writers
         if ($urandom_range(3) == 0)
            write_csr(rrcs_pkg::CSR_WRITER_COUNT, {32'($urandom), 27'($urandom),
                      ($urandom_range(1) ? 5'($urandom_range(4)) : 5'($urandom_range(31)))});
         if ($urandom_range(1)) begin
            case ($urandom_range(5))
               0:       limit = '0;
               1:       limit = '1;
               2:       limit = {$urandom, $urandom};
               default: limit = {$urandom, $urandom} >> $urandom_range(63, 28);
            endcase
            write_csr(rrcs_pkg::CSR_BASE_LIMIT, limit);
         end
         if ($urandom_range(1)) begin
            case ($urandom_range(5))
               0:       limit = '0;
               1:       limit = '1;
               2:       limit = {$urandom, $urandom};
               default: limit = rrcs_pkg::CNT_W'($urandom_range(12, 1));
            endcase
            write_csr(rrcs_pkg::CSR_RECORD_LIMIT, limit);
         end
         if ($urandom_range(15) == 0)
            write_csr(CSR_UNMAPPED, {$urandom, $urandom});
         settle();

         batch = hold_off_done ? $urandom_range(60, 10) : 60;
         for (int i = 0; i < batch; i++) begin
            case ($urandom_range(7))
               0:       len = '0;
               1:       len = '1;
               2:       len = $urandom_range(1000);
               default: len = $urandom;
            endcase
            queued_lengths.push_back(len);
         end
         random_sent += batch;

         // once, stall the receiver while a full batch is still on offer
         if (!hold_off_done && random_sent > 200) begin
            hold_off_request = 1'b1;
            hold_off_done    = 1'b1;
         end
      end

      // drain, let the block run on idle, then report
      settle();
      repeat (4) @(negedge clock);
      if (error_count == 0 && expected_placements.size() == 0) begin
         $display("PASS round_robin_chunk_splitter");
      end else begin
         $display("FAIL round_robin_chunk_splitter");
      end
      $finish;
   end

endmodule
